// ----- hw/rtl/occupancy_grid_ray_update_unit_macros.svh -----
// ----------------------------------------------------------------------------
// occupancy grid ray update - assertion macros
// shared concurrent assertion forms for the grid update block
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define OGRU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define OGRU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ogru_pkg.sv -----
// ----------------------------------------------------------------------------
// ogru_pkg
// shared types and widths of the occupancy grid ray update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ogru_pkg;

   localparam int COORD_W   = 16;   // signed ray endpoint coordinate
   localparam int QUERY_W   = 8;    // read coordinate
   localparam int CNT_W     = 13;   // cell counters, wrap in 13 bits
   localparam int RAY_CNT_W = 32;   // ray counters, wrap in 32 bits

   typedef enum logic [1:0] {
      CELL_UNKNOWN   = 2'd0,
      CELL_FREE      = 2'd1,
      CELL_CANDIDATE = 2'd2,
      CELL_OCCUPIED  = 2'd3
   } cell_state_type;

endpackage

// ----- hw/rtl/ogru_grid_ram.sv -----
// ----------------------------------------------------------------------------
// ogru_grid_ram
// cell store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ogru_grid_ram import ogru_pkg::*; #(
   parameter int  DEPTH  = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_state_type    wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_state_type    rd_data
);

   cell_state_type mem [DEPTH];
   cell_state_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/occupancy_grid_ray_update_unit.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update_unit
// occupancy grid kept in a cell ram, updated by a bresenham ray walk
// ----------------------------------------------------------------------------
// usage
//   req channel (req_valid / req_stall): one item per request. func 0 walks a
//   ray from start to end cell, marking unknown cells free and promoting the
//   end cell; func 1 reads the cell at query_x / query_y.
//   rsp channel (rsp_valid / rsp_stall): exactly one item per request, with
//   the cell counts and ray counts as they stand after the request.
//   a ray covers n = max(|dx|, |dy|) + 1 cells, with one ram read and at most
//   one ram write per cell on the single cell ram; a dropped ray and an off
//   grid read go straight to the response, an on-grid read reads one cell.
//   throughput: one request in flight, req_stall is high until the request
//   has been handed to the response register.
//   reset: all counters clear, then a clearing pass writes unknown to every
//   cell, one cell per cycle, with req_stall high.
//   a stalled response holds in the output register; a finished request
//   waits for that register to free up before the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "occupancy_grid_ray_update_unit_macros.svh"

module occupancy_grid_ray_update_unit import ogru_pkg::*; #(
   parameter int GRID_SIDE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic signed [COORD_W-1:0]   req_start_x,
   input  logic signed [COORD_W-1:0]   req_start_y,
   input  logic signed [COORD_W-1:0]   req_end_x,
   input  logic signed [COORD_W-1:0]   req_end_y,
   input  logic [QUERY_W-1:0]          req_query_x,
   input  logic [QUERY_W-1:0]          req_query_y,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_accepted,
   output logic [1:0]                  rsp_cell_state,
   output logic [CNT_W-1:0]            rsp_observed_count,
   output logic [CNT_W-1:0]            rsp_candidate_count,
   output logic [CNT_W-1:0]            rsp_occupied_count,
   output logic [RAY_CNT_W-1:0]        rsp_rays_done,
   output logic [RAY_CNT_W-1:0]        rsp_rays_dropped
);

   localparam int CELLS  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CRD_W  = $clog2(GRID_SIDE);
   localparam int ERR_W  = CRD_W + 4;

   localparam logic [ADDR_W-1:0]       SIDE_A    = ADDR_W'(GRID_SIDE);
   localparam logic [ADDR_W-1:0]       LAST_A    = ADDR_W'(CELLS - 1);
   localparam logic [COORD_W-1:0]      SIDE_C    = COORD_W'(GRID_SIDE);
   localparam logic [QUERY_W:0]        SIDE_Q    = (QUERY_W + 1)'(GRID_SIDE);
   localparam logic [CRD_W-1:0]        MAX_CRD   = CRD_W'(GRID_SIDE - 1);
   localparam logic signed [ERR_W-1:0] ERR_LIM   = ERR_W'(2 * GRID_SIDE);

   typedef enum logic [2:0] {
      S_CLEAR,    // post-reset sweep of the cell ram
      S_IDLE,     // waiting for a request
      S_RD,       // present walk cell address to the ram
      S_WR,       // read data back: update cell, counters, step the walk
      S_QRD,      // present query address
      S_QDATA,    // capture query cell
      S_DONE      // hand result to the response register
   } state_type;

   // sequencer and walk state
   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [CRD_W-1:0]         x_ff, x_in, y_ff, y_in;
   logic [CRD_W-1:0]         x1_ff, x1_in, y1_ff, y1_in;
   logic [CRD_W-1:0]         dx_ff, dx_in, dym_ff, dym_in;
   logic                     sxn_ff, sxn_in, syn_ff, syn_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic                     res_acc_ff, res_acc_in;
   cell_state_type           res_cell_ff, res_cell_in;

   // running totals
   logic [CNT_W-1:0]         obs_ff, obs_in, cand_ff, cand_in, occ_ff, occ_in;
   logic [RAY_CNT_W-1:0]     rays_ff, rays_in, drops_ff, drops_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_acc_ff, rsp_acc_in;
   cell_state_type           rsp_cell_ff, rsp_cell_in;
   logic [CNT_W-1:0]         rsp_obs_ff, rsp_obs_in;
   logic [CNT_W-1:0]         rsp_cand_ff, rsp_cand_in;
   logic [CNT_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic [RAY_CNT_W-1:0]     rsp_rays_ff, rsp_rays_in;
   logic [RAY_CNT_W-1:0]     rsp_drops_ff, rsp_drops_in;

   // cell ram hookup
   logic                     ram_we;
   logic [ADDR_W-1:0]        ram_wr_addr;
   cell_state_type           ram_wr_data;
   logic [ADDR_W-1:0]        cur_addr;
   cell_state_type           ram_rd_data;

   // request decode
   logic                     req_take;
   logic                     ray_on_grid, query_on_grid;
   logic [CRD_W-1:0]         rx0, ry0, rx1, ry1;
   logic [CRD_W-1:0]         init_dx, init_dym;

   // walk step
   logic                     at_end, step_x, step_y;
   logic signed [ERR_W-1:0]  e2, dx_s, neg_dym;

   function automatic logic coord_ok(input logic [COORD_W-1:0] c);
      return !c[COORD_W-1] && (c < SIDE_C);
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;

   assign ray_on_grid = coord_ok(req_start_x) && coord_ok(req_start_y) &&
                        coord_ok(req_end_x) && coord_ok(req_end_y);
   assign query_on_grid = ({1'b0, req_query_x} < SIDE_Q) &&
                          ({1'b0, req_query_y} < SIDE_Q);

   // on-grid endpoints fit in CRD_W bits
   assign rx0 = req_start_x[CRD_W-1:0];
   assign ry0 = req_start_y[CRD_W-1:0];
   assign rx1 = req_end_x[CRD_W-1:0];
   assign ry1 = req_end_y[CRD_W-1:0];
   assign init_dx  = (rx1 > rx0) ? (rx1 - rx0) : (rx0 - rx1);
   assign init_dym = (ry1 > ry0) ? (ry1 - ry0) : (ry0 - ry1);

   // row-major cell address of the walk / query cursor
   assign cur_addr = ADDR_W'(y_ff) * SIDE_A + ADDR_W'(x_ff);

   // bresenham decision on the current error term
   assign dx_s    = signed'({{(ERR_W - CRD_W){1'b0}}, dx_ff});
   assign neg_dym = -signed'({{(ERR_W - CRD_W){1'b0}}, dym_ff});
   assign e2      = err_ff <<< 1;
   assign step_x  = (e2 >= neg_dym);
   assign step_y  = (e2 <= dx_s);
   assign at_end  = (x_ff == x1_ff) && (y_ff == y1_ff);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      dx_in        = dx_ff;
      dym_in       = dym_ff;
      sxn_in       = sxn_ff;
      syn_in       = syn_ff;
      err_in       = err_ff;
      res_acc_in   = res_acc_ff;
      res_cell_in  = res_cell_ff;
      obs_in       = obs_ff;
      cand_in      = cand_ff;
      occ_in       = occ_ff;
      rays_in      = rays_ff;
      drops_in     = drops_ff;
      // response is taken whenever it is not stalled
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_obs_in   = rsp_obs_ff;
      rsp_cand_in  = rsp_cand_ff;
      rsp_occ_in   = rsp_occ_ff;
      rsp_rays_in  = rsp_rays_ff;
      rsp_drops_in = rsp_drops_ff;
      ram_we       = 1'b0;
      ram_wr_addr  = cur_addr;
      ram_wr_data  = CELL_UNKNOWN;

      case (state_ff)
         S_CLEAR: begin
            ram_we      = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_A) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_take) begin
               res_acc_in  = 1'b1;
               res_cell_in = CELL_UNKNOWN;
               if (req_func) begin
                  x_in = req_query_x[CRD_W-1:0];
                  y_in = req_query_y[CRD_W-1:0];
                  state_in = query_on_grid ? S_QRD : S_DONE;
               end else if (!ray_on_grid) begin
                  res_acc_in = 1'b0;
                  drops_in   = drops_ff + RAY_CNT_W'(1);
                  state_in   = S_DONE;
               end else begin
                  x_in     = rx0;
                  y_in     = ry0;
                  x1_in    = rx1;
                  y1_in    = ry1;
                  dx_in    = init_dx;
                  dym_in   = init_dym;
                  sxn_in   = !(rx0 < rx1);
                  syn_in   = !(ry0 < ry1);
                  err_in   = signed'({{(ERR_W - CRD_W){1'b0}}, init_dx}) -
                             signed'({{(ERR_W - CRD_W){1'b0}}, init_dym});
                  state_in = S_RD;
               end
            end
         end

         S_RD: begin
            state_in = S_WR;
         end

         S_WR: begin
            if (at_end) begin
               // promote the end cell
               case (ram_rd_data)
                  CELL_UNKNOWN: begin
                     ram_we      = 1'b1;
                     ram_wr_data = CELL_CANDIDATE;
                     obs_in      = obs_ff + CNT_W'(1);
                     cand_in     = cand_ff + CNT_W'(1);
                  end
                  CELL_FREE: begin
                     ram_we      = 1'b1;
                     ram_wr_data = CELL_CANDIDATE;
                     cand_in     = cand_ff + CNT_W'(1);
                  end
                  CELL_CANDIDATE: begin
                     ram_we      = 1'b1;
                     ram_wr_data = CELL_OCCUPIED;
                     cand_in     = cand_ff - CNT_W'(1);
                     occ_in      = occ_ff + CNT_W'(1);
                  end
                  default: begin
                     // occupied stays occupied
                  end
               endcase
               rays_in  = rays_ff + RAY_CNT_W'(1);
               state_in = S_DONE;
            end else begin
               // pass-through cell: unknown becomes free
               if (ram_rd_data == CELL_UNKNOWN) begin
                  ram_we      = 1'b1;
                  ram_wr_data = CELL_FREE;
                  obs_in      = obs_ff + CNT_W'(1);
               end
               if (step_x) begin
                  x_in = sxn_ff ? (x_ff - CRD_W'(1)) : (x_ff + CRD_W'(1));
               end
               if (step_y) begin
                  y_in = syn_ff ? (y_ff - CRD_W'(1)) : (y_ff + CRD_W'(1));
               end
               err_in = err_ff + (step_x ? neg_dym : '0) + (step_y ? dx_s : '0);
               state_in = S_RD;
            end
         end

         S_QRD: begin
            state_in = S_QDATA;
         end

         S_QDATA: begin
            res_cell_in = ram_rd_data;
            state_in    = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_acc_ff;
               rsp_cell_in  = res_cell_ff;
               rsp_obs_in   = obs_ff;
               rsp_cand_in  = cand_ff;
               rsp_occ_in   = occ_ff;
               rsp_rays_in  = rays_ff;
               rsp_drops_in = drops_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      // payload, no reset needed
      x_ff         <= x_in;
      y_ff         <= y_in;
      x1_ff        <= x1_in;
      y1_ff        <= y1_in;
      dx_ff        <= dx_in;
      dym_ff       <= dym_in;
      sxn_ff       <= sxn_in;
      syn_ff       <= syn_in;
      err_ff       <= err_in;
      res_acc_ff   <= res_acc_in;
      res_cell_ff  <= res_cell_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_cell_ff  <= rsp_cell_in;
      rsp_obs_ff   <= rsp_obs_in;
      rsp_cand_ff  <= rsp_cand_in;
      rsp_occ_ff   <= rsp_occ_in;
      rsp_rays_ff  <= rsp_rays_in;
      rsp_drops_ff <= rsp_drops_in;
      // control and totals
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         obs_ff       <= '0;
         cand_ff      <= '0;
         occ_ff       <= '0;
         rays_ff      <= '0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         obs_ff       <= obs_in;
         cand_ff      <= cand_in;
         occ_ff       <= occ_in;
         rays_ff      <= rays_in;
         drops_ff     <= drops_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ogru_grid_ram #(
      .DEPTH (CELLS)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cur_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_acc_ff;
   assign rsp_cell_state      = rsp_cell_ff;
   assign rsp_observed_count  = rsp_obs_ff;
   assign rsp_candidate_count = rsp_cand_ff;
   assign rsp_occupied_count  = rsp_occ_ff;
   assign rsp_rays_done       = rsp_rays_ff;
   assign rsp_rays_dropped    = rsp_drops_ff;

   // a taken request always starts work
   `OGRU_ASSERT_NEXT(a_take_leaves_idle, clock, reset, req_take,
      state_ff != S_IDLE, "request taken but sequencer stayed idle")

   // the walk cursor never leaves the grid
   `OGRU_ASSERT_SAME(a_walk_on_grid, clock, reset, state_ff == S_WR,
      (x_ff <= MAX_CRD) && (y_ff <= MAX_CRD), "walk cursor left the grid")

   // error term stays well inside its width
   `OGRU_ASSERT_SAME(a_err_bounded, clock, reset, state_ff == S_RD,
      (err_ff >= -ERR_LIM) && (err_ff <= ERR_LIM), "bresenham error out of range")

   // cell ram is written only by the clear pass or a walk update
   `OGRU_ASSERT_SAME(a_ram_write_src, clock, reset, ram_we,
      (state_ff == S_CLEAR) || (state_ff == S_WR), "unexpected cell ram write")

endmodule
